FILE: rtl/lfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the magnetic line-follow steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

    // Sensor bar and motor drive sizing.
    localparam int SENSOR_COUNT = 6;
    localparam int MAG_W        = 8;
    localparam int PWM_FULL     = 100;
    localparam int PULSE_LIM    = PWM_FULL - 1;
    localparam int PULSE_W      = $clog2(PULSE_LIM + 1) + 1;
    localparam int DUTY_W       = 7;

    // Magnitude sums.
    localparam int ABS_W  = MAG_W;
    localparam int SUM_W  = $clog2(SENSOR_COUNT * (1 << (MAG_W - 1)) + 1);
    localparam int HALF_W = $clog2((SENSOR_COUNT / 2) * (1 << (MAG_W - 1)) + 1);
    localparam int ERR_W  = HALF_W + 1;

    // Configuration register widths and reset values.
    localparam int SPEED_W  = 8;
    localparam int CARD_W   = 8;
    localparam int THR_W    = 7;
    localparam int FLOOR_W  = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(30);
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = CFG_IDX_W'(3);

    // Turn level ladder: level 0 is the widest turn.
    localparam int NUM_LEVELS = 5;
    localparam int OFF_W      = 5;
    localparam int BOUND_W    = THR_W + $clog2(NUM_LEVELS + 1);
    localparam int RAW_W      = SPEED_W + 2;
    localparam logic [3:0]       LEVEL_LEFT [NUM_LEVELS] = '{4'd11, 4'd9, 4'd7, 4'd5, 4'd3};
    localparam logic [OFF_W-1:0] LEVEL_OFF  [NUM_LEVELS] = '{5'd19, 5'd13, 5'd7, 5'd3, 5'd1};

    // Opcodes.
    localparam logic [2:0] OP_MAG    = 3'd0;
    localparam logic [2:0] OP_CARD   = 3'd1;
    localparam logic [2:0] OP_OBST   = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;
    localparam logic [2:0] OP_NUDGE  = 3'd6;

    // Bridge modes.
    localparam logic [1:0] MODE_BRAKE = 2'd0;
    localparam logic [1:0] MODE_COAST = 2'd1;
    localparam logic [1:0] MODE_FWD   = 2'd2;
    localparam logic [1:0] MODE_REV   = 2'd3;

    // Steering states.
    localparam logic [3:0] STEER_STOP = 4'd0;
    localparam logic [3:0] STEER_FWD  = 4'd1;

    typedef logic signed [MAG_W-1:0] t_mag;

    // Pre-decoded input word handed from the front stage to the core.
    typedef struct packed {
        logic [2:0]       opcode;
        logic             no_line;
        logic             in_band;
        logic             turn_hit;
        logic             turn_left;
        logic [3:0]       turn_code;
        logic [OFF_W-1:0] turn_off;
        logic             card_match;
        logic             ir_a_clear;
        logic             ir_b_clear;
        logic             motor_select;
        logic             nudge_down;
    } t_item;

    typedef struct packed {
        logic [1:0]        a_mode;
        logic [DUTY_W-1:0] a_duty;
        logic [1:0]        b_mode;
        logic [DUTY_W-1:0] b_duty;
        logic [3:0]        steer;
        logic              obstacle;
        logic              poll;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/lfs_frame.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_frame
// Decodes one incoming word: sensor magnitudes, line presence, steering
// error against the threshold ladder, and card match.
// ----------------------------------------------------------------------------
module lfs_frame (
    input  wire logic [2:0]                  i_opcode,
    input  wire lfs_pkg::t_mag               i_mag [lfs_pkg::SENSOR_COUNT],
    input  wire logic [lfs_pkg::CARD_W-1:0]  i_card_id,
    input  wire logic                        i_ir_a_clear,
    input  wire logic                        i_ir_b_clear,
    input  wire logic                        i_motor_select,
    input  wire logic                        i_nudge_down,
    input  wire logic [lfs_pkg::CARD_W-1:0]  i_target_card,
    input  wire logic [lfs_pkg::THR_W-1:0]   i_steer_threshold,
    input  wire logic [lfs_pkg::FLOOR_W-1:0] i_signal_floor,
    output lfs_pkg::t_item                   o_item
);
    import lfs_pkg::*;

    localparam int CMP_W = (SUM_W > FLOOR_W) ? SUM_W : FLOOR_W;

    logic [ABS_W-1:0]        mag_abs [SENSOR_COUNT];
    logic [SUM_W-1:0]        mag_sum;
    logic [HALF_W-1:0]       left_sum;
    logic [HALF_W-1:0]       right_sum;
    logic signed [ERR_W-1:0] err;
    logic [HALF_W-1:0]       err_abs;
    logic [BOUND_W-1:0]      bound [NUM_LEVELS];
    logic                    hit;
    logic [3:0]              code;
    logic [OFF_W-1:0]        off;

    always_comb begin
        mag_sum   = '0;
        left_sum  = '0;
        right_sum = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            mag_abs[i] = i_mag[i][MAG_W-1] ? ABS_W'(-i_mag[i]) : ABS_W'(i_mag[i]);
            mag_sum    = mag_sum + SUM_W'(mag_abs[i]);
            if (i < SENSOR_COUNT / 2) begin
                left_sum = left_sum + HALF_W'(mag_abs[i]);
            end else begin
                right_sum = right_sum + HALF_W'(mag_abs[i]);
            end
        end
        err     = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        err_abs = err[ERR_W-1] ? HALF_W'(-err) : HALF_W'(err);
    end

    // The widest turn has priority, so the scan runs from the narrowest level
    // and lets a wider match overwrite it.
    always_comb begin
        hit  = 1'b0;
        code = STEER_STOP;
        off  = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            bound[i] = BOUND_W'((NUM_LEVELS - i) * i_steer_threshold);
            if (BOUND_W'(err_abs) > bound[i]) begin
                hit  = 1'b1;
                code = LEVEL_LEFT[i] + {3'b000, ~err[ERR_W-1]};
                off  = LEVEL_OFF[i];
            end
        end
    end

    always_comb begin
        o_item.opcode       = i_opcode;
        o_item.no_line      = CMP_W'(mag_sum) < CMP_W'(i_signal_floor);
        o_item.in_band      = BOUND_W'(err_abs) < BOUND_W'(i_steer_threshold);
        o_item.turn_hit     = hit;
        o_item.turn_left    = err[ERR_W-1];
        o_item.turn_code    = code;
        o_item.turn_off     = off;
        o_item.card_match   = i_card_id == i_target_card;
        o_item.ir_a_clear   = i_ir_a_clear;
        o_item.ir_b_clear   = i_ir_b_clear;
        o_item.motor_select = i_motor_select;
        o_item.nudge_down   = i_nudge_down;
    end

endmodule

`default_nettype wire

FILE: rtl/lfs_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_core
// Vehicle state, motor pulses and bridge modes. Applies one decoded word per
// cycle while i_fire is high and registers the resulting drive word.
// ----------------------------------------------------------------------------
module lfs_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire lfs_pkg::t_item              i_item,
    input  wire logic [lfs_pkg::SPEED_W-1:0] i_cruise_speed,
    output lfs_pkg::t_result                 o_result
);
    import lfs_pkg::*;

    localparam logic signed [RAW_W-1:0] LIM_POS = RAW_W'(PULSE_LIM);
    localparam logic signed [RAW_W-1:0] LIM_NEG = -RAW_W'(PULSE_LIM);

    function automatic logic signed [PULSE_W-1:0] sat_pulse(
        input logic signed [RAW_W-1:0] p
    );
        logic signed [RAW_W-1:0] q;
        q = p;
        if (p > LIM_POS) begin
            q = LIM_POS;
        end else if (p < LIM_NEG) begin
            q = LIM_NEG;
        end
        return PULSE_W'(q);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [PULSE_W-1:0] p);
        logic [PULSE_W-1:0] m;
        m = p[PULSE_W-1] ? PULSE_W'(-p) : PULSE_W'(p);
        return m[DUTY_W-1:0];
    endfunction

    logic [3:0]                r_moving, n_moving;
    logic [3:0]                r_saved, n_saved;
    logic                      r_obst, n_obst;
    logic signed [PULSE_W-1:0] r_pulse [2];
    logic signed [PULSE_W-1:0] n_pulse [2];
    logic [1:0]                r_mode [2];
    logic [1:0]                n_mode [2];
    logic                      n_poll;
    logic                      do_set [2];
    logic signed [RAW_W-1:0]   raw [2];
    logic signed [RAW_W-1:0]   spd;
    logic signed [RAW_W-1:0]   off;
    logic signed [RAW_W-1:0]   step;
    logic                      blocked;
    t_result                   r_result, n_result;

    always_comb begin
        spd     = $signed(RAW_W'(i_cruise_speed));
        off     = i_item.turn_left ? -$signed(RAW_W'(i_item.turn_off))
                                   : $signed(RAW_W'(i_item.turn_off));
        step    = i_item.nudge_down ? -RAW_W'(1) : RAW_W'(1);
        blocked = !i_item.ir_a_clear || !i_item.ir_b_clear;

        n_moving = r_moving;
        n_saved  = r_saved;
        n_obst   = r_obst;
        n_poll   = 1'b0;
        for (int m = 0; m < 2; m++) begin
            n_mode[m] = r_mode[m];
            do_set[m] = 1'b0;
            raw[m]    = '0;
        end

        case (i_item.opcode)
            OP_MAG: begin
                if (r_moving != STEER_STOP) begin
                    if (i_item.no_line) begin
                        do_set[0] = 1'b1;
                        do_set[1] = 1'b1;
                    end else if (i_item.in_band) begin
                        n_moving  = STEER_FWD;
                        do_set[0] = 1'b1;
                        do_set[1] = 1'b1;
                        raw[0]    = spd;
                        raw[1]    = spd;
                    end else if (i_item.turn_hit && r_moving != i_item.turn_code) begin
                        n_moving  = i_item.turn_code;
                        do_set[0] = 1'b1;
                        do_set[1] = 1'b1;
                        raw[0]    = spd + off;
                        raw[1]    = spd - off;
                    end
                end
            end
            OP_CARD: begin
                if (i_item.card_match) begin
                    n_moving  = STEER_STOP;
                    n_mode[0] = MODE_BRAKE;
                    n_mode[1] = MODE_BRAKE;
                end
            end
            OP_OBST: begin
                if (blocked && !r_obst) begin
                    n_obst    = 1'b1;
                    n_saved   = r_moving;
                    n_moving  = STEER_STOP;
                    n_mode[0] = MODE_BRAKE;
                    n_mode[1] = MODE_BRAKE;
                end else if (!blocked && r_obst) begin
                    n_obst   = 1'b0;
                    n_moving = r_saved;
                end
            end
            OP_START: begin
                n_moving  = STEER_FWD;
                n_mode[0] = MODE_FWD;
                n_mode[1] = MODE_FWD;
            end
            OP_STOP: begin
                n_moving  = STEER_STOP;
                n_mode[0] = MODE_BRAKE;
                n_mode[1] = MODE_BRAKE;
            end
            OP_TICK: begin
                n_poll = r_moving != STEER_STOP;
            end
            OP_NUDGE: begin
                do_set[i_item.motor_select] = 1'b1;
                raw[i_item.motor_select] = RAW_W'(r_pulse[i_item.motor_select]) + step;
            end
            default: begin
            end
        endcase

        // A zero pulse counts as reverse, matching the drive convention.
        for (int m = 0; m < 2; m++) begin
            n_pulse[m] = r_pulse[m];
            if (do_set[m]) begin
                n_pulse[m] = sat_pulse(raw[m]);
                n_mode[m]  = (n_pulse[m] > 0) ? MODE_FWD : MODE_REV;
            end
        end

        n_result.a_mode   = n_mode[0];
        n_result.a_duty   = duty_of(n_pulse[0]);
        n_result.b_mode   = n_mode[1];
        n_result.b_duty   = duty_of(n_pulse[1]);
        n_result.steer    = n_moving;
        n_result.obstacle = n_obst;
        n_result.poll     = n_poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving <= STEER_STOP;
            r_saved  <= STEER_STOP;
            r_obst   <= 1'b0;
            for (int m = 0; m < 2; m++) begin
                r_pulse[m] <= '0;
                r_mode[m]  <= MODE_BRAKE;
            end
        end else if (i_fire) begin
            r_moving <= n_moving;
            r_saved  <= n_saved;
            r_obst   <= n_obst;
            for (int m = 0; m < 2; m++) begin
                r_pulse[m] <= n_pulse[m];
                r_mode[m]  <= n_mode[m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/magnetic_line_follow_steering_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetic_line_follow_steering_top
// Two-wheel steering controller for a vehicle following a magnetic line.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word per accepted edge: an opcode
// with the six sensor values, a card id, the two infrared flags and the nudge
// fields. Output channel: o_valid / i_stall carry exactly one drive word per
// input word: both bridge modes and duties, the steering state, the obstacle
// flag and the poll request.
// The word is decoded into an input register, then the state update writes the
// result register. Throughput is one word per cycle while the receiver does not
// stall; the path that sets it is the state update in lfs_core.
// While the receiver stalls, the result register holds its word and the input
// register can still take one more word; o_stall rises only when both are
// full. Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data, by the user only while the block is idle; nothing enforces it.
// Reset (synchronous, active low) empties both registers, stops the vehicle,
// clears the pulses, brakes both motors and loads the register defaults.
// ----------------------------------------------------------------------------
module magnetic_line_follow_steering_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_cfg_we,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lfs_pkg::CFG_W-1:0]     i_cfg_data,

    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [2:0]                    i_opcode,
    input  wire logic signed [7:0]             i_mag_0,
    input  wire logic signed [7:0]             i_mag_1,
    input  wire logic signed [7:0]             i_mag_2,
    input  wire logic signed [7:0]             i_mag_3,
    input  wire logic signed [7:0]             i_mag_4,
    input  wire logic signed [7:0]             i_mag_5,
    input  wire logic [7:0]                    i_card_id,
    input  wire logic                          i_ir_a_clear,
    input  wire logic                          i_ir_b_clear,
    input  wire logic                          i_motor_select,
    input  wire logic                          i_nudge_down,

    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [1:0]                    o_drive_a_mode,
    output      logic [6:0]                    o_drive_a_duty,
    output      logic [1:0]                    o_drive_b_mode,
    output      logic [6:0]                    o_drive_b_duty,
    output      logic [3:0]                    o_steer_state,
    output      logic                          o_obstacle_seen,
    output      logic                          o_poll_request
);
    import lfs_pkg::*;

    logic [SPEED_W-1:0] r_cruise_speed;
    logic [CARD_W-1:0]  r_target_card;
    logic [THR_W-1:0]   r_steer_threshold;
    logic [FLOOR_W-1:0] r_signal_floor;

    t_mag    mag_arr [SENSOR_COUNT];
    t_item   dec_item;
    t_item   r_item;
    logic    r_s1_valid;
    logic    r_out_valid;
    logic    advance;
    logic    fire;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise_speed    <= '0;
            r_target_card     <= '0;
            r_steer_threshold <= THR_RESET;
            r_signal_floor    <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CRUISE: r_cruise_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_TARGET: r_target_card     <= i_cfg_data[CARD_W-1:0];
                CFG_THRESH: r_steer_threshold <= i_cfg_data[THR_W-1:0];
                CFG_FLOOR:  r_signal_floor    <= i_cfg_data[FLOOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign mag_arr[0] = i_mag_0;
    assign mag_arr[1] = i_mag_1;
    assign mag_arr[2] = i_mag_2;
    assign mag_arr[3] = i_mag_3;
    assign mag_arr[4] = i_mag_4;
    assign mag_arr[5] = i_mag_5;

    lfs_frame u_frame (
        .i_opcode          (i_opcode),
        .i_mag             (mag_arr),
        .i_card_id         (i_card_id),
        .i_ir_a_clear      (i_ir_a_clear),
        .i_ir_b_clear      (i_ir_b_clear),
        .i_motor_select    (i_motor_select),
        .i_nudge_down      (i_nudge_down),
        .i_target_card     (r_target_card),
        .i_steer_threshold (r_steer_threshold),
        .i_signal_floor    (r_signal_floor),
        .o_item            (dec_item)
    );

    // The result register frees up when it is empty or its word is taken.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_s1_valid && advance;
    assign o_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= dec_item;
        end
    end

    lfs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_item),
        .i_cruise_speed (r_cruise_speed),
        .o_result       (result)
    );

    assign o_valid         = r_out_valid;
    assign o_drive_a_mode  = result.a_mode;
    assign o_drive_a_duty  = result.a_duty;
    assign o_drive_b_mode  = result.b_mode;
    assign o_drive_b_duty  = result.b_duty;
    assign o_steer_state   = result.steer;
    assign o_obstacle_seen = result.obstacle;
    assign o_poll_request  = result.poll;

endmodule

`default_nettype wire
